[design/lcfsb_pkg.sv]
// shared types and constants for the led chain frame store and bar block
// no dependencies; imported by the controller, the datapath and the top level
package lcfsb_pkg;

    // number of leds in the chain, two per board
    localparam int LED_TOTAL   = 20;
    localparam int BOARD_COUNT = LED_TOTAL / 2;
    // one slot per board, plus one for an unpaired led on an odd chain
    localparam int SLOT_COUNT  = (LED_TOTAL + 1) / 2;
    localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // field widths
    localparam int CMD_W    = 3;
    localparam int IDX_W    = 5;
    localparam int COLOR_W  = 8;
    localparam int PERIOD_W = 7;
    localparam int MS_W     = 7;
    localparam int BYTE_W   = 8;
    localparam int BOARD_W  = 4;

    // elapsed time wraps at this many milliseconds
    localparam int MS_WRAP      = 100;
    localparam int PERIOD_RESET = 10;

    // bar position = LED_TOTAL * elapsed / 100, done as a reciprocal multiply
    localparam int RECIP_SHIFT = 19;
    localparam int RECIP_100   = 5243;
    localparam int POS_MULT    = LED_TOTAL * RECIP_100;
    localparam int POS_MULT_W  = $clog2(POS_MULT + 1);
    localparam int PROD_W      = MS_W + POS_MULT_W;
    localparam int POS_W       = $clog2(LED_TOTAL);

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_SET_ONE = 3'd0,
        CMD_SET_ALL = 3'd1,
        CMD_CLEAR   = 3'd2,
        CMD_UPDATE  = 3'd3,
        CMD_TICK    = 3'd4
    } cmd_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK_POS,
        ST_TICK_CHECK,
        ST_SEND
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic set_one;
        logic set_all;
        logic clear;
        logic tick_add;
        logic tick_pos;
        logic bar_fill;
        logic send;
    } dp_ctrl_t;

    // datapath to controller status
    typedef struct packed {
        logic pos_changed;
        logic last_board;
    } dp_status_t;

endpackage

[design/lcfsb_ctrl.sv]
// controller state machine for the led chain frame store and bar block
// depends on lcfsb_pkg; drives the datapath through dp_ctrl_t
module lcfsb_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  lcfsb_pkg::cmd_t       cmd,
    input  lcfsb_pkg::dp_status_t status,
    output lcfsb_pkg::dp_ctrl_t   ctrl,
    output logic                  busy
);
    import lcfsb_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = start && (state_reg == ST_IDLE);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (cmd)
                        CMD_UPDATE: state_next = ST_SEND;
                        CMD_TICK:   state_next = ST_TICK_POS;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_TICK_POS:
            begin
                state_next = ST_TICK_CHECK;
            end
            ST_TICK_CHECK:
            begin
                state_next = status.pos_changed ? ST_SEND : ST_IDLE;
            end
            ST_SEND:
            begin
                if (status.last_board)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        ctrl          = '0;
        busy          = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy          = 1'b0;
                ctrl.set_one  = accept && (cmd == CMD_SET_ONE);
                ctrl.set_all  = accept && (cmd == CMD_SET_ALL);
                ctrl.clear    = accept && (cmd == CMD_CLEAR);
                ctrl.tick_add = accept && (cmd == CMD_TICK);
            end
            ST_TICK_POS:
            begin
                ctrl.tick_pos = 1'b1;
            end
            ST_TICK_CHECK:
            begin
                ctrl.bar_fill = status.pos_changed;
            end
            ST_SEND:
            begin
                ctrl.send = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

[design/lcfsb_datapath.sv]
// datapath: led on-bit store, elapsed time and bar position, byte output stage
// depends on lcfsb_pkg; commanded by lcfsb_ctrl
module lcfsb_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lcfsb_pkg::dp_ctrl_t               ctrl,
    output lcfsb_pkg::dp_status_t             status,
    input  logic [lcfsb_pkg::IDX_W-1:0]       led_index,
    input  logic [lcfsb_pkg::COLOR_W-1:0]     red,
    input  logic [lcfsb_pkg::COLOR_W-1:0]     green,
    input  logic [lcfsb_pkg::COLOR_W-1:0]     blue,
    input  logic                              period_we,
    input  logic [lcfsb_pkg::PERIOD_W-1:0]    period_data,
    output logic [lcfsb_pkg::BYTE_W-1:0]      shift_byte,
    output logic [lcfsb_pkg::BOARD_W-1:0]     board_index,
    output logic                              last,
    output logic                              result_valid
);
    import lcfsb_pkg::*;

    // slot bits [5:3] first led, [2:0] second led; each red, green, blue
    logic [5:0]          slot_reg [SLOT_COUNT];
    logic [5:0]          slot_next [SLOT_COUNT];
    logic [PERIOD_W-1:0] period_reg;
    logic [MS_W-1:0]     elapsed_reg;
    logic [MS_W-1:0]     elapsed_next;
    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    bar_reg;
    logic [SLOT_W-1:0]   cnt_reg;
    logic [BYTE_W-1:0]   byte_reg;
    logic [BOARD_W-1:0]  board_reg;
    logic                last_reg;
    logic                strobe_reg;
    logic [2:0]          color;
    logic [MS_W:0]       sum;
    logic [MS_W:0]       wrap1;
    logic [MS_W:0]       wrap2;
    logic [PROD_W-1:0]   prod;

    assign color = {red != '0, green != '0, blue != '0};

    // elapsed plus period, reduced modulo 100 with two conditional subtracts
    always_comb
    begin
        sum   = {1'b0, elapsed_reg} + {1'b0, period_reg};
        wrap1 = (sum >= (MS_W+1)'(MS_WRAP)) ? sum - (MS_W+1)'(MS_WRAP) : sum;
        wrap2 = (wrap1 >= (MS_W+1)'(MS_WRAP)) ? wrap1 - (MS_W+1)'(MS_WRAP) : wrap1;
        elapsed_next = wrap2[MS_W-1:0];
    end

    // bar position by reciprocal multiply
    assign prod = PROD_W'(elapsed_reg) * PROD_W'(POS_MULT);

    // led store update
    always_comb
    begin
        for (int k = 0; k < SLOT_COUNT; k++)
        begin
            slot_next[k] = slot_reg[k];
            if (ctrl.set_one && (int'(led_index) == 2 * k))
            begin
                slot_next[k][5:3] = color;
            end
            if (ctrl.set_one && (int'(led_index) == 2 * k + 1)
                && (2 * k + 1 < LED_TOTAL))
            begin
                slot_next[k][2:0] = color;
            end
            if (ctrl.set_all)
            begin
                slot_next[k] = {color, color};
            end
            if (ctrl.clear)
            begin
                slot_next[k] = '0;
            end
            if (ctrl.bar_fill)
            begin
                slot_next[k][5:3] = (2 * k < int'(pos_reg)) ? 3'b111 : 3'b000;
                slot_next[k][2:0] = (2 * k + 1 < int'(pos_reg)) ? 3'b111 : 3'b000;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SLOT_COUNT; k++)
            begin
                slot_reg[k] <= '0;
            end
        end
        else
        begin
            for (int k = 0; k < SLOT_COUNT; k++)
            begin
                slot_reg[k] <= slot_next[k];
            end
        end
    end

    // period register, elapsed time, bar position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg  <= PERIOD_W'(PERIOD_RESET);
            elapsed_reg <= '0;
            bar_reg     <= '0;
        end
        else
        begin
            if (period_we)
            begin
                period_reg <= period_data;
            end
            if (ctrl.tick_add)
            begin
                elapsed_reg <= elapsed_next;
            end
            if (ctrl.bar_fill)
            begin
                bar_reg <= pos_reg;
            end
        end
    end

    // new position, held for the compare in the next cycle
    always_ff @(posedge clk)
    begin
        if (ctrl.tick_pos)
        begin
            pos_reg <= prod[RECIP_SHIFT +: POS_W];
        end
    end

    // board counter walks the slots during a send
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= ctrl.send;
            if (ctrl.send)
            begin
                cnt_reg <= status.last_board ? '0 : cnt_reg + 1'b1;
            end
        end
    end

    // output item registers
    always_ff @(posedge clk)
    begin
        if (ctrl.send)
        begin
            byte_reg  <= {slot_reg[cnt_reg], 2'b00};
            board_reg <= BOARD_W'(cnt_reg);
            last_reg  <= status.last_board;
        end
    end

    assign status.pos_changed = (pos_reg != bar_reg);
    assign status.last_board  = (cnt_reg == SLOT_W'(BOARD_COUNT - 1));

    assign shift_byte   = byte_reg;
    assign board_index  = board_reg;
    assign last         = last_reg;
    assign result_valid = strobe_reg;

endmodule

[design/led_chain_frame_store_and_bar_top.sv]
// top level of the led chain frame store and bar block
// depends on lcfsb_pkg, lcfsb_ctrl and lcfsb_datapath
//
// Command channel: an item is taken at a clock edge with start high and busy
// low. Set one, set all and clear change the store at that edge; busy stays
// low. Update sends one item per board, BOARD_COUNT (10 here) in all, with
// busy high while they are sent; the items appear one per cycle, the first
// after the state register and then the output item registers, each on
// result_valid for one cycle, last set on the final one. Tick adds the
// period, multiplies for the bar position, then compares; if the bar moved,
// the bar is drawn and a full update follows. The board counter sending one
// byte per cycle sets the update length. Result items cannot be held off;
// the receiver must take them as shown. Config channel: cfg_ready is always
// high; a write with cfg_valid loads tick_period_ms, and the user must make
// it only while the block is idle, which the block does not enforce. Reset
// clears every led, elapsed time and bar position, and sets the tick period
// to 10 ms; the block is ready in the first cycle after reset.
module led_chain_frame_store_and_bar_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [lcfsb_pkg::CMD_W-1:0]       command,
    input  logic [lcfsb_pkg::IDX_W-1:0]       led_index,
    input  logic [lcfsb_pkg::COLOR_W-1:0]     red,
    input  logic [lcfsb_pkg::COLOR_W-1:0]     green,
    input  logic [lcfsb_pkg::COLOR_W-1:0]     blue,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lcfsb_pkg::PERIOD_W-1:0]    tick_period_ms,
    output logic                              result_valid,
    output logic [lcfsb_pkg::BYTE_W-1:0]      shift_byte,
    output logic [lcfsb_pkg::BOARD_W-1:0]     board_index,
    output logic                              last
);
    import lcfsb_pkg::*;

    dp_ctrl_t   ctrl;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    // controller
    lcfsb_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd_t'(command)),
        .status (status),
        .ctrl   (ctrl),
        .busy   (busy)
    );

    // datapath
    lcfsb_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .status       (status),
        .led_index    (led_index),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .period_we    (cfg_valid && cfg_ready),
        .period_data  (tick_period_ms),
        .shift_byte   (shift_byte),
        .board_index  (board_index),
        .last         (last),
        .result_valid (result_valid)
    );

endmodule

[bench/tb_led_chain_frame_store_and_bar_top.sv]
`timescale 1ns / 1ps
// testbench for led_chain_frame_store_and_bar_top: a directed command table, then random
// commands over several tick periods; depends on lcfsb_pkg and the block's rtl only
module tb_led_chain_frame_store_and_bar_top;
    import lcfsb_pkg::*;

    localparam int CLK_HALF        = 6;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEMS_PER_PHASE = 21;
    localparam int PERIOD_PHASES   = 6;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DIRECTED_ROWS   = 25;
    localparam int IDX_MAX         = (1 << IDX_W) - 1;

    // commands the block does not decode
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

    typedef struct packed {
        logic [BYTE_W-1:0]  byte_val;
        logic [BOARD_W-1:0] board;
        logic               is_last;
    } board_byte_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [IDX_W-1:0]   idx;
        logic [COLOR_W-1:0] r;
        logic [COLOR_W-1:0] g;
        logic [COLOR_W-1:0] b;
        logic               typed;
        logic [BYTE_W-1:0]  typed_byte;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [CMD_W-1:0]    command;
    logic [IDX_W-1:0]    led_index;
    logic [COLOR_W-1:0]  red;
    logic [COLOR_W-1:0]  green;
    logic [COLOR_W-1:0]  blue;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [PERIOD_W-1:0] tick_period_ms;
    logic                result_valid;
    logic [BYTE_W-1:0]   shift_byte;
    logic [BOARD_W-1:0]  board_index;
    logic                last;

    // predicted frame store state
    logic [2:0]          led_on [LED_TOTAL];
    int                  elapsed;
    int                  bar_pos;
    logic [PERIOD_W-1:0] period_now;

    board_byte_t         board_bytes_due[$];
    board_byte_t         head;
    int                  failures = 0;
    int                  cycle_count = 0;
    int                  items_sent;
    int                  bytes_checked = 0;
    int                  frames_sent;
    bit                  use_gaps;

    // update rows carry one byte expected on every board where it is plain
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{CMD_UPDATE,  5'd0,  8'h00, 8'h00, 8'h00, 1'b1, 8'h00},
        '{CMD_SET_ALL, 5'd0,  8'hff, 8'hff, 8'hff, 1'b0, 8'h00},
        '{CMD_UPDATE,  5'd0,  8'h00, 8'h00, 8'h00, 1'b1, 8'hfc},
        '{CMD_CLEAR,   5'd31, 8'hff, 8'hff, 8'hff, 1'b0, 8'h00},
        '{CMD_UPDATE,  5'd0,  8'h00, 8'h00, 8'h00, 1'b1, 8'h00},
        '{CMD_SET_ONE, 5'd0,  8'h01, 8'h00, 8'h00, 1'b0, 8'h00},
        '{CMD_SET_ONE, 5'd19, 8'h00, 8'h00, 8'h80, 1'b0, 8'h00},
        '{CMD_SET_ONE, 5'd20, 8'hff, 8'hff, 8'hff, 1'b0, 8'h00},
        '{CMD_SET_ONE, 5'd31, 8'hff, 8'hff, 8'hff, 1'b0, 8'h00},
        '{CMD_SET_ONE, 5'd1,  8'h00, 8'h80, 8'h00, 1'b0, 8'h00},
        '{CMD_SET_ONE, 5'd10, 8'hff, 8'hff, 8'h00, 1'b0, 8'h00},
        '{CMD_UPDATE,  5'd0,  8'h00, 8'h00, 8'h00, 1'b0, 8'h00},
        '{CMD_SPARE_A, 5'd0,  8'hff, 8'hff, 8'hff, 1'b0, 8'h00},
        '{CMD_SPARE_B, 5'd5,  8'hff, 8'hff, 8'hff, 1'b0, 8'h00},
        '{CMD_SPARE_C, 5'd31, 8'hff, 8'hff, 8'hff, 1'b0, 8'h00},
        '{CMD_UPDATE,  5'd0,  8'h00, 8'h00, 8'h00, 1'b0, 8'h00},
        '{CMD_SET_ALL, 5'd0,  8'h00, 8'h01, 8'h00, 1'b0, 8'h00},
        '{CMD_UPDATE,  5'd0,  8'h00, 8'h00, 8'h00, 1'b1, 8'h48},
        '{CMD_TICK,    5'd0,  8'h00, 8'h00, 8'h00, 1'b0, 8'h00},
        '{CMD_TICK,    5'd0,  8'h00, 8'h00, 8'h00, 1'b0, 8'h00},
        '{CMD_SET_ALL, 5'd0,  8'h55, 8'haa, 8'h01, 1'b0, 8'h00},
        '{CMD_UPDATE,  5'd0,  8'h00, 8'h00, 8'h00, 1'b1, 8'hfc},
        '{CMD_CLEAR,   5'd0,  8'h00, 8'h00, 8'h00, 1'b0, 8'h00},
        '{CMD_TICK,    5'd0,  8'h00, 8'h00, 8'h00, 1'b0, 8'h00},
        '{CMD_UPDATE,  5'd0,  8'h00, 8'h00, 8'h00, 1'b0, 8'h00}
    };

    led_chain_frame_store_and_bar_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .led_index      (led_index),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .tick_period_ms (tick_period_ms),
        .result_valid   (result_valid),
        .shift_byte     (shift_byte),
        .board_index    (board_index),
        .last           (last)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // queue one packed byte per board from the predicted store
    task automatic push_frame();
        board_byte_t e;
        for (int k = 0; k < BOARD_COUNT; k++)
        begin
            e.byte_val = {led_on[2*k], led_on[2*k+1], 2'b00};
            e.board    = BOARD_W'(k);
            e.is_last  = (k == BOARD_COUNT - 1);
            board_bytes_due.push_back(e);
        end
        frames_sent++;
    endtask

    // same byte on every board, for rows whose frame is obvious
    task automatic push_flat_frame(input logic [BYTE_W-1:0] val);
        board_byte_t e;
        for (int k = 0; k < BOARD_COUNT; k++)
        begin
            e.byte_val = val;
            e.board    = BOARD_W'(k);
            e.is_last  = (k == BOARD_COUNT - 1);
            board_bytes_due.push_back(e);
        end
        frames_sent++;
    endtask

    // apply one accepted command to the predicted store
    task automatic step_frame_store(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                                    input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
                                    input logic [COLOR_W-1:0] b, input bit record);
        logic [2:0] col;
        int         pos;
        col = {r != '0, g != '0, b != '0};
        case (cmd)
            CMD_SET_ONE:
                if (idx < LED_TOTAL)
                    led_on[idx] = col;
            CMD_SET_ALL:
                foreach (led_on[i])
                    led_on[i] = col;
            CMD_CLEAR:
                foreach (led_on[i])
                    led_on[i] = 3'b000;
            CMD_UPDATE:
                if (record)
                    push_frame();
            CMD_TICK:
            begin
                elapsed = (elapsed + int'(period_now)) % MS_WRAP;
                pos     = (LED_TOTAL * elapsed) / MS_WRAP;
                // bar moved: redraw white below it and send
                if (pos != bar_pos)
                begin
                    bar_pos = pos;
                    foreach (led_on[i])
                        led_on[i] = (i < pos) ? 3'b111 : 3'b000;
                    if (record)
                        push_frame();
                end
            end
            default: ;
        endcase
    endtask

    // offer one item and hold it until the block takes it
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                             input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
                             input logic [COLOR_W-1:0] b);
        @(negedge clk);
        start     <= 1'b1;
        command   <= cmd;
        led_index <= idx;
        red       <= r;
        green     <= g;
        blue      <= b;
        do @(posedge clk); while (busy);
        items_sent++;
    endtask

    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // stop sending and let every expected byte arrive, then let a quiet tick finish
    task automatic wait_frames_done();
        @(negedge clk);
        start <= 1'b0;
        while (board_bytes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_period(input logic [PERIOD_W-1:0] val);
        wait_frames_done();
        @(negedge clk);
        cfg_valid      <= 1'b1;
        tick_period_ms <= val;
        do @(posedge clk); while (!cfg_ready);
        period_now = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // colour value, zero about a third of the time
    function automatic logic [COLOR_W-1:0] rand_colour();
        if ($urandom_range(0, 2) == 0)
            return '0;
        return COLOR_W'($urandom_range(1, 255));
    endfunction

    task automatic random_item();
        int                 pick;
        logic [CMD_W-1:0]   cmd;
        logic [IDX_W-1:0]   idx;
        logic [COLOR_W-1:0] r;
        logic [COLOR_W-1:0] g;
        logic [COLOR_W-1:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            cmd = CMD_SET_ONE;
        else if (pick < 35)
            cmd = CMD_SET_ALL;
        else if (pick < 42)
            cmd = CMD_CLEAR;
        else if (pick < 58)
            cmd = CMD_UPDATE;
        else if (pick < 92)
            cmd = CMD_TICK;
        else
        begin
            case ($urandom_range(0, 2))
                0:       cmd = CMD_SPARE_A;
                1:       cmd = CMD_SPARE_B;
                default: cmd = CMD_SPARE_C;
            endcase
        end
        // mostly valid leds, some past the end of the chain
        if ($urandom_range(0, 6) == 0)
            idx = IDX_W'($urandom_range(LED_TOTAL, IDX_MAX));
        else
            idx = IDX_W'($urandom_range(0, LED_TOTAL - 1));
        r = rand_colour();
        g = rand_colour();
        b = rand_colour();
        send_item(cmd, idx, r, g, b);
        step_frame_store(cmd, idx, r, g, b, 1'b1);
    endtask

    // result checker and run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d bytes still expected", $time,
                     board_bytes_due.size());
            $display("Test completed with failures");
            $finish;
        end
        else if (rst_n && result_valid)
        begin
            if (board_bytes_due.size() == 0)
            begin
                $display("%0t: unexpected item byte %h board %0d last %0b", $time,
                         shift_byte, board_index, last);
                failures++;
            end
            else
            begin
                head = board_bytes_due.pop_front();
                bytes_checked++;
                if (shift_byte !== head.byte_val)
                begin
                    $display("%0t: shift_byte expected %h actual %h", $time,
                             head.byte_val, shift_byte);
                    failures++;
                end
                if (board_index !== head.board)
                begin
                    $display("%0t: board_index expected %0d actual %0d", $time,
                             head.board, board_index);
                    failures++;
                end
                if (last !== head.is_last)
                begin
                    $display("%0t: last expected %0b actual %0b", $time, head.is_last, last);
                    failures++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        logic [PERIOD_W-1:0] periods [PERIOD_PHASES];
        stim_row_t           row;
        items_sent     = 0;
        frames_sent    = 0;
        use_gaps       = 1'b1;
        rst_n          = 1'b0;
        start          = 1'b0;
        command        = '0;
        led_index      = '0;
        red            = '0;
        green          = '0;
        blue           = '0;
        cfg_valid      = 1'b0;
        tick_period_ms = '0;
        foreach (led_on[i])
            led_on[i] = 3'b000;
        elapsed    = 0;
        bar_pos    = 0;
        period_now = PERIOD_W'(PERIOD_RESET);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table at the reset period
        for (int n = 0; n < DIRECTED_ROWS; n++)
        begin
            row = directed_rows[n];
            send_item(row.cmd, row.idx, row.r, row.g, row.b);
            step_frame_store(row.cmd, row.idx, row.r, row.g, row.b, !row.typed);
            if (row.typed)
                push_flat_frame(row.typed_byte);
        end

        // zero, smallest, largest in range, register maximum, random, then back to reset
        periods[0] = '0;
        periods[1] = PERIOD_W'(1);
        periods[2] = PERIOD_W'(MS_WRAP - 1);
        periods[3] = '1;
        periods[4] = PERIOD_W'($urandom_range(2, MS_WRAP - 2));
        periods[5] = PERIOD_W'(PERIOD_RESET);

        for (int p = 0; p < PERIOD_PHASES; p++)
        begin
            write_period(periods[p]);
            use_gaps = (p != PERIOD_PHASES - 1);
            repeat (ITEMS_PER_PHASE)
            begin
                if (use_gaps && $urandom_range(0, 3) == 0)
                    idle_cycles($urandom_range(1, 14));
                random_item();
            end
        end

        wait_frames_done();
        $display("%0d commands taken, %0d frames with %0d board bytes compared", items_sent,
                 frames_sent, bytes_checked);
        $display("tick periods run: 10 0 1 99 127 %0d 10", periods[4]);
        if (failures == 0 && board_bytes_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
